/* hw/rtl/rppfc_pkg.sv */
// Shared types, format codes and arithmetic constants of the pixel pair format converter.
package rppfc_pkg;

	// Output format codes; codes 6 and 7 are unused and give all-zero words
	typedef enum logic [2:0] {
		FMT_RGB32  = 3'd0,
		FMT_RGB24  = 3'd1,
		FMT_RGB565 = 3'd2,
		FMT_RGB555 = 3'd3,
		FMT_YUY2   = 3'd4,
		FMT_UYVY   = 3'd5
	} fmt_t;

	// Input beat: two horizontally adjacent pixels, R 23..16, G 15..8, B 7..0
	typedef struct packed {
		logic [23:0] pixel_a;
		logic [23:0] pixel_b;
	} pixel_pair_t;

	// Result beat
	typedef struct packed {
		logic [31:0] word_a;
		logic [31:0] word_b;
	} word_pair_t;

	// Y of both pixels and the pair's averaged chroma
	typedef struct packed {
		logic [7:0] y0;
		logic [7:0] y1;
		logic [7:0] u;
		logic [7:0] v;
	} yuv_pair_t;

	// Numerator width: every BT.601 numerator here stays below 2^18
	localparam int NUM_W = 18;
	// Working width for the signed-free mod-2^19 sums
	localparam int SUM_W = NUM_W + 1;

	// BT.601 studio-range coefficients scaled by 1000
	localparam logic [SUM_W-1:0] COEF_YR   = SUM_W'(257);
	localparam logic [SUM_W-1:0] COEF_YG   = SUM_W'(504);
	localparam logic [SUM_W-1:0] COEF_YB   = SUM_W'(98);
	localparam logic [SUM_W-1:0] COEF_UR   = SUM_W'(148);
	localparam logic [SUM_W-1:0] COEF_UG   = SUM_W'(291);
	localparam logic [SUM_W-1:0] COEF_UB   = SUM_W'(439);
	localparam logic [SUM_W-1:0] COEF_VR   = SUM_W'(439);
	localparam logic [SUM_W-1:0] COEF_VG   = SUM_W'(368);
	localparam logic [SUM_W-1:0] COEF_VB   = SUM_W'(71);
	localparam logic [SUM_W-1:0] Y_OFFSET  = SUM_W'(16000);
	localparam logic [SUM_W-1:0] UV_OFFSET = SUM_W'(128000);

	// floor(x / 1000) = (x * ceil(2^28 / 1000)) >> 28, exact for x below 493447
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP_W     = 19;
	localparam logic [RECIP_W-1:0] RECIP_MUL =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd999) / 64'd1000);
	localparam int PROD_W = NUM_W + RECIP_W;

endpackage

/* hw/rtl/rppfc_rgb_pack.sv */
// RGB packing of a pixel pair: copy, RGB24, RGB565 and RGB555.
module rppfc_rgb_pack (
	input  rppfc_pkg::fmt_t        fmt,
	input  rppfc_pkg::pixel_pair_t pixels,
	output rppfc_pkg::word_pair_t  words
);
	import rppfc_pkg::*;

	// Format select; YUV and unused codes give zero here
	always_comb begin
		case (fmt)
			FMT_RGB32, FMT_RGB24: begin
				words.word_a = {8'b0, pixels.pixel_a};
				words.word_b = {8'b0, pixels.pixel_b};
			end
			FMT_RGB565: begin
				words.word_a = {16'b0, pixels.pixel_a[23:19], pixels.pixel_a[15:10],
					pixels.pixel_a[7:3]};
				words.word_b = {16'b0, pixels.pixel_b[23:19], pixels.pixel_b[15:10],
					pixels.pixel_b[7:3]};
			end
			FMT_RGB555: begin
				words.word_a = {17'b0, pixels.pixel_a[23:19], pixels.pixel_a[15:11],
					pixels.pixel_a[7:3]};
				words.word_b = {17'b0, pixels.pixel_b[23:19], pixels.pixel_b[15:11],
					pixels.pixel_b[7:3]};
			end
			default: begin
				words = '0;
			end
		endcase
	end

endmodule

/* hw/rtl/rppfc_yuv_pipe.sv */
// Two-stage BT.601 YUV pipeline: numerators, then divide by 1000 via reciprocal multiply.
module rppfc_yuv_pipe (
	input  logic                   clk,
	input  rppfc_pkg::pixel_pair_t pixels,
	output rppfc_pkg::yuv_pair_t   yuv
);
	import rppfc_pkg::*;

	typedef struct packed {
		logic [NUM_W-1:0] ny;
		logic [NUM_W-1:0] nu;
		logic [NUM_W-1:0] nv;
	} num_t;

	// RGB565 round trip with bit replication, then scaled Y/U/V numerators.
	// All numerators are positive, so mod-2^19 sums give the exact value.
	function automatic num_t numer(input logic [23:0] p);
		logic [SUM_W-1:0] r;
		logic [SUM_W-1:0] g;
		logic [SUM_W-1:0] b;
		logic [SUM_W-1:0] sy;
		logic [SUM_W-1:0] su;
		logic [SUM_W-1:0] sv;
		num_t n;
		r  = {(SUM_W-8)'(0), p[23:19], p[23:21]};
		g  = {(SUM_W-8)'(0), p[15:10], p[15:14]};
		b  = {(SUM_W-8)'(0), p[7:3], p[7:5]};
		sy = r * COEF_YR + g * COEF_YG + b * COEF_YB + Y_OFFSET;
		su = b * COEF_UB + UV_OFFSET - r * COEF_UR - g * COEF_UG;
		sv = r * COEF_VR + UV_OFFSET - g * COEF_VG - b * COEF_VB;
		n.ny = sy[NUM_W-1:0];
		n.nu = su[NUM_W-1:0];
		n.nv = sv[NUM_W-1:0];
		return n;
	endfunction

	// floor(x / 1000); quotient never exceeds 239, so it fits the 8-bit result without a clamp
	function automatic logic [7:0] div1000(input logic [NUM_W-1:0] x);
		logic [PROD_W-1:0] prod;
		prod = {(PROD_W-NUM_W)'(0), x} * {(PROD_W-RECIP_W)'(0), RECIP_MUL};
		return prod[RECIP_SHIFT+7:RECIP_SHIFT];
	endfunction

	num_t num_a_s2, num_b_s2;
	logic [7:0] y0_s3, u0_s3, v0_s3, y1_s3, u1_s3, v1_s3;
	logic [8:0] u_sum, v_sum;

	// Stage 2: numerators
	always_ff @(posedge clk) begin
		num_a_s2 <= numer(pixels.pixel_a);
		num_b_s2 <= numer(pixels.pixel_b);
	end

	// Stage 3: quotients
	always_ff @(posedge clk) begin
		y0_s3 <= div1000(num_a_s2.ny);
		u0_s3 <= div1000(num_a_s2.nu);
		v0_s3 <= div1000(num_a_s2.nv);
		y1_s3 <= div1000(num_b_s2.ny);
		u1_s3 <= div1000(num_b_s2.nu);
		v1_s3 <= div1000(num_b_s2.nv);
	end

	// Floor average of the pair's chroma
	assign u_sum  = {1'b0, u0_s3} + {1'b0, u1_s3};
	assign v_sum  = {1'b0, v0_s3} + {1'b0, v1_s3};
	assign yuv.y0 = y0_s3;
	assign yuv.y1 = y1_s3;
	assign yuv.u  = u_sum[8:1];
	assign yuv.v  = v_sum[8:1];

endmodule

/* hw/rtl/rgb_pixel_pair_format_converter.sv */
// Top level of the RGB pixel pair format converter.
// A pixel pair is taken on every clock edge with start high; busy is always low, so a new
// pair may follow in every cycle. Each result comes out with done high for one cycle, after
// its pair has passed the input register, YUV numerator stage, reciprocal-multiply divide
// stage and result register. The receiver cannot stall; results are never held. The
// output format register is written with cfg_wr_en and should only change between pairs.
module rgb_pixel_pair_format_converter (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [2:0]             cfg_wr_data,
	input  logic                   start,
	output logic                   busy,
	input  rppfc_pkg::pixel_pair_t pixels,
	output logic                   done,
	output rppfc_pkg::word_pair_t  result
);
	import rppfc_pkg::*;

	fmt_t        fmt_q;
	logic        valid_s1, valid_s2, valid_s3;
	fmt_t        fmt_s1, fmt_s2, fmt_s3;
	pixel_pair_t pix_s1;
	word_pair_t  rgb_comb, rgb_s2, rgb_s3;
	yuv_pair_t   yuv_s3;
	word_pair_t  result_d, result_q;
	logic        done_q;

	// Never stalls
	assign busy = 1'b0;

	// Format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RGB32;
		end else if (cfg_wr_en) begin
			fmt_q <= fmt_t'(cfg_wr_data);
		end
	end

	// Valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			pix_s1 <= pixels;
			fmt_s1 <= fmt_q;
		end
	end

	rppfc_rgb_pack u_rgb_pack (
		.fmt    (fmt_s1),
		.pixels (pix_s1),
		.words  (rgb_comb)
	);

	rppfc_yuv_pipe u_yuv_pipe (
		.clk    (clk),
		.pixels (pix_s1),
		.yuv    (yuv_s3)
	);

	// RGB words and format follow the YUV pipe latency
	always_ff @(posedge clk) begin
		rgb_s2 <= rgb_comb;
		fmt_s2 <= fmt_s1;
		rgb_s3 <= rgb_s2;
		fmt_s3 <= fmt_s2;
	end

	// Final format select
	always_comb begin
		case (fmt_s3)
			FMT_YUY2: begin
				result_d.word_a = {16'b0, yuv_s3.u, yuv_s3.y0};
				result_d.word_b = {16'b0, yuv_s3.v, yuv_s3.y1};
			end
			FMT_UYVY: begin
				result_d.word_a = {16'b0, yuv_s3.y0, yuv_s3.u};
				result_d.word_b = {16'b0, yuv_s3.y1, yuv_s3.v};
			end
			default: begin
				result_d = rgb_s3;
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	assign done   = done_q;
	assign result = result_q;

	// Every accepted pair produces a result with done high
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("accepted pair produced no result");

	// No result without an earlier accepted pair
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result without accepted pair");

	// Valid stages move in lockstep
	a_valid_chain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $past(valid_s1))
		else $error("pipeline valid skipped a stage");

endmodule
